// ===== rtl/mpi_pkg.sv =====
`timescale 1ns / 1ps

package mpi_pkg;

	// reply queue geometry
	localparam int FIFO_DEPTH = 16;
	localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// reset address of the data port
	localparam logic [15:0] BASE_PORT_RESET = 16'd816;

	// host command codes
	localparam logic [7:0] CMD_UART_MODE = 8'h3F;
	localparam logic [7:0] CMD_RESET     = 8'hFF;
	localparam logic [7:0] CMD_VERSION_A = 8'hAC;
	localparam logic [7:0] CMD_VERSION_B = 8'hAD;
	localparam logic [7:0] CMD_INFO      = 8'hE7;
	localparam logic [7:0] CMD_PARAM_A   = 8'hE0;
	localparam logic [7:0] CMD_PARAM_B   = 8'hE4;
	localparam logic [7:0] CMD_PARAM_C   = 8'hE6;

	// reply bytes
	localparam logic [7:0] ACK_BYTE      = 8'hFE;
	localparam logic [7:0] REPLY_VERSION = 8'h01;
	localparam logic [7:0] REPLY_INFO    = 8'h04;

	// read values
	localparam logic [7:0] STATUS_EMPTY = 8'h80;
	localparam logic [7:0] STATUS_READY = 8'h00;
	localparam logic [7:0] OPEN_BUS     = 8'hFF;

	// midi byte classes
	localparam logic [7:0] MIDI_SYSEX_START = 8'hF0;
	localparam logic [7:0] MIDI_SYSEX_END   = 8'hF7;
	localparam logic [7:0] MIDI_REALTIME    = 8'hF8;
	localparam logic [3:0] KIND_NOTE_OFF    = 4'h8;
	localparam logic [3:0] KIND_NOTE_ON     = 4'h9;
	localparam logic [3:0] KIND_PROGRAM     = 4'hC;
	localparam logic [3:0] KIND_PRESSURE    = 4'hD;

	// request to the reply queue for one transfer
	typedef struct packed {
		logic       flush;
		logic [1:0] push_n;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       pop;
	} fifo_req_t;

	typedef struct packed {
		logic       empty;
		logic [7:0] head;
	} fifo_stat_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] channel;
		logic [3:0] kind;
		logic [6:0] first;
		logic [6:0] second;
	} midi_event_t;

endpackage

// ===== rtl/mpi_reply_fifo.sv =====
`timescale 1ns / 1ps

module mpi_reply_fifo
	import mpi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  fifo_req_t  req,
	output fifo_stat_t stat
);

	logic [7:0]       mem [FIFO_DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;

	logic [PTR_W-1:0] head_base;
	logic [CNT_W-1:0] count_base;
	logic [CNT_W:0]   tail_sum;
	logic [PTR_W-1:0] tail0;
	logic [PTR_W-1:0] tail1;
	logic             wr0;
	logic             wr1;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_comb begin
		head_base  = req.flush ? '0 : head_q;
		count_base = req.flush ? '0 : count_q;
		tail_sum   = (CNT_W+1)'(head_base) + (CNT_W+1)'(count_base);
		if (tail_sum >= (CNT_W+1)'(FIFO_DEPTH)) begin
			tail_sum = tail_sum - (CNT_W+1)'(FIFO_DEPTH);
		end
		tail0  = tail_sum[PTR_W-1:0];
		tail1  = ptr_inc(tail0);
		// pushes beyond the free space are dropped
		wr0    = (req.push_n != 2'd0) && (count_base < CNT_W'(FIFO_DEPTH));
		wr1    = (req.push_n == 2'd2) && (count_base < CNT_W'(FIFO_DEPTH - 1));
		do_pop = req.pop && (count_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (do_pop) begin
			head_q  <= ptr_inc(head_q);
			count_q <= count_q - CNT_W'(1);
		end else begin
			head_q  <= head_base;
			count_q <= count_base + CNT_W'(wr0) + CNT_W'(wr1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr0) begin
			mem[tail0] <= req.byte0;
		end
		if (wr1) begin
			mem[tail1] <= req.byte1;
		end
	end

	assign stat.empty = (count_q == '0);
	assign stat.head  = mem[head_q];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("reply queue count beyond depth");

	a_flush_ack: assert property (@(posedge clk) disable iff (!arst_n)
		req.flush && req.push_n == 2'd1 |=> count_q == CNT_W'(1) && head_q == '0)
		else $error("flush with ack did not leave one byte");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		req.pop && count_q != '0 |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("pop did not take one byte");

endmodule

// ===== rtl/mpi_parser.sv =====
`timescale 1ns / 1ps

module mpi_parser
	import mpi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        clear,
	input  logic [7:0]  data,
	output midi_event_t ev
);

	logic       sysex_q, sysex_n;
	logic [7:0] status_q, status_n;
	logic       count_q, count_n;
	logic [1:0] needed_q, needed_n;
	logic [6:0] first_q, first_n;
	midi_event_t ev_c;

	always_comb begin
		sysex_n  = sysex_q;
		status_n = status_q;
		count_n  = count_q;
		needed_n = needed_q;
		first_n  = first_q;
		ev_c     = '0;
		priority if (sysex_q) begin
			if (data == MIDI_SYSEX_END) begin
				sysex_n = 1'b0;
			end
		end else if (data >= MIDI_REALTIME || data == MIDI_SYSEX_END) begin
			// realtime and stray end of sysex pass by
		end else if (data >= MIDI_SYSEX_START) begin
			sysex_n  = (data == MIDI_SYSEX_START);
			status_n = '0;
			count_n  = 1'b0;
			needed_n = 2'd0;
		end else if (data[7]) begin
			status_n = data;
			count_n  = 1'b0;
			needed_n = (data[7:4] == KIND_PROGRAM || data[7:4] == KIND_PRESSURE) ? 2'd1 : 2'd2;
		end else if (status_q == '0) begin
			// data with no running status
		end else if (!count_q && needed_q >= 2'd2) begin
			first_n = data[6:0];
			count_n = 1'b1;
		end else begin
			ev_c.valid   = 1'b1;
			ev_c.channel = status_q[3:0];
			if (needed_q >= 2'd2) begin
				ev_c.first  = first_q;
				ev_c.second = data[6:0];
			end else begin
				first_n     = data[6:0];
				ev_c.first  = data[6:0];
				ev_c.second = '0;
			end
			ev_c.kind = (status_q[7:4] == KIND_NOTE_ON && ev_c.second == '0) ?
				KIND_NOTE_OFF : status_q[7:4];
			count_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sysex_q  <= 1'b0;
			status_q <= '0;
			count_q  <= 1'b0;
			needed_q <= 2'd0;
			first_q  <= '0;
		end else if (clear) begin
			sysex_q  <= 1'b0;
			status_q <= '0;
			count_q  <= 1'b0;
			needed_q <= 2'd0;
			first_q  <= '0;
		end else if (en) begin
			sysex_q  <= sysex_n;
			status_q <= status_n;
			count_q  <= count_n;
			needed_q <= needed_n;
			first_q  <= first_n;
		end
	end

	assign ev = en ? ev_c : '0;

endmodule

// ===== rtl/midi_port_interface_unit.sv =====
`timescale 1ns / 1ps

// midi port interface: one host bus access per input transfer, one result
// transfer per access. the data port sits at base_port and the status/command
// port at base_port+1 (never matched when base_port is 0xffff). reads of the
// status port give 0x80 while the reply queue is empty, reads of the data port
// pop the queue (0 when empty), and any other address reads 0xff. commands in
// intelligent mode queue an ack 0xfe and some a reply byte; e0, e4 and e6
// instead take one parameter byte on the data port, 3f enters uart mode and
// ff resets the port from either mode. data-port writes feed a midi parser
// that drops sysex and realtime bytes, keeps running status and reports each
// channel message on event_valid, with note-on at velocity 0 shown as
// note-off. the queue holds 16 bytes; pushes to a full queue are lost. one
// transfer per cycle while m_tready is high; an access enters an input
// register, is decoded in a single pass through the queue and parser logic,
// and its result sits in the output register. base_port is written by the
// user via cfg_we/cfg_wdata only while no access is in flight (not enforced).

module midi_port_interface_unit
	import mpi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,     // base_port
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,       // port[15:0], write_data[23:16]
	input  logic        s_tuser,       // mode (0 read, 1 write)
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,       // read_data[7:0], event_channel[11:8],
	                                   // event_kind[15:12], event_first[22:16],
	                                   // event_second[29:23], zero[31:30]
	output logic        m_tuser        // event_valid
);

	// configuration and mode state
	logic [15:0] base_q;
	logic        uart_q, uart_n;
	logic        pend_q, pend_n;

	// input register
	logic        valid_s1;
	logic        mode_s1;
	logic [15:0] port_s1;
	logic [7:0]  wdata_s1;

	// result register
	logic        valid_s2;
	logic [7:0]  rdata_s2;
	midi_event_t ev_s2;

	logic        adv;
	logic        is_cmd;
	logic        is_data;
	logic [7:0]  rd;
	fifo_req_t   fifo_req;
	fifo_stat_t  fifo_stat;
	logic        parse_en;
	logic        parse_clear;
	midi_event_t ev;

	// the stage moves when the result register is free or being drained
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	// address decode; command port compare is one bit wider so it never wraps
	assign is_cmd  = ({1'b0, port_s1} == ({1'b0, base_q} + 17'd1));
	assign is_data = (port_s1 == base_q);

	always_comb begin
		rd          = '0;
		fifo_req    = '0;
		parse_en    = 1'b0;
		parse_clear = 1'b0;
		uart_n      = uart_q;
		pend_n      = pend_q;
		if (adv) begin
			if (!mode_s1) begin
				priority if (is_cmd) begin
					rd = fifo_stat.empty ? STATUS_EMPTY : STATUS_READY;
				end else if (is_data) begin
					fifo_req.pop = 1'b1;
					rd = fifo_stat.empty ? 8'h00 : fifo_stat.head;
				end else begin
					rd = OPEN_BUS;
				end
			end else if (is_cmd) begin
				if (wdata_s1 == CMD_RESET) begin
					// port reset in either mode: empty queue, single ack
					fifo_req.flush  = 1'b1;
					fifo_req.push_n = 2'd1;
					fifo_req.byte0  = ACK_BYTE;
					parse_clear     = 1'b1;
					pend_n          = 1'b0;
					uart_n          = 1'b0;
				end else if (!uart_q) begin
					pend_n         = 1'b0;
					fifo_req.byte0 = ACK_BYTE;
					unique case (wdata_s1)
						CMD_UART_MODE: begin
							fifo_req.push_n = 2'd1;
							uart_n          = 1'b1;
						end
						CMD_VERSION_A, CMD_VERSION_B: begin
							fifo_req.push_n = 2'd2;
							fifo_req.byte1  = REPLY_VERSION;
						end
						CMD_INFO: begin
							fifo_req.push_n = 2'd2;
							fifo_req.byte1  = REPLY_INFO;
						end
						CMD_PARAM_A, CMD_PARAM_B, CMD_PARAM_C: begin
							pend_n = 1'b1;
						end
						default: begin
							fifo_req.push_n = 2'd1;
						end
					endcase
				end
			end else if (is_data) begin
				if (!uart_q && pend_q) begin
					// parameter byte is swallowed and acknowledged
					pend_n          = 1'b0;
					fifo_req.push_n = 2'd1;
					fifo_req.byte0  = ACK_BYTE;
				end else begin
					parse_en = 1'b1;
				end
			end
		end
	end

	mpi_reply_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fifo_req),
		.stat   (fifo_stat)
	);

	mpi_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (parse_en),
		.clear  (parse_clear),
		.data   (wdata_s1),
		.ev     (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= BASE_PORT_RESET;
			uart_q   <= 1'b0;
			pend_q   <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			uart_q <= uart_n;
			pend_q <= pend_n;
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1  <= s_tuser;
			port_s1  <= s_tdata[15:0];
			wdata_s1 <= s_tdata[23:16];
		end
		if (adv) begin
			rdata_s2 <= rd;
			ev_s2    <= ev;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = ev_s2.valid;
	assign m_tdata  = {2'b00, ev_s2.second, ev_s2.first, ev_s2.kind, ev_s2.channel, rdata_s2};

	a_event_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[7:0] == 8'h00)
		else $error("event transfer carries read data");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[29:8] == '0)
		else $error("event fields set without an event");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(port_s1) && $stable(wdata_s1))
		else $error("blocked access lost from input register");

endmodule

// ===== tb/midi_port_interface_unit_test.sv =====
`timescale 1ns / 1ps

module midi_port_interface_unit_test;
	import mpi_pkg::*;

	localparam int LATENCY    = 2;
	localparam int SETTLE     = LATENCY + 4;
	localparam int IDLE_LIMIT = 1000;
	localparam int MAX_PRINTS = 50;

	// one expected bus result, fields as they leave the block
	typedef struct {
		logic [7:0] read_data;
		logic       ev_valid;
		logic [3:0] channel;
		logic [3:0] kind;
		logic [6:0] first;
		logic [6:0] second;
	} bus_result_t;

	// tracks the port state and the results each accepted access must produce
	class midi_port_tracker;
		logic [15:0] base;
		bit          uart_on;
		bit          param_due;
		bit          in_sysex;
		logic [7:0]  run_status;
		int          held;
		int          needed;
		logic [6:0]  first_byte;
		logic [7:0]  reply_bytes[$];
		bus_result_t due[$];
		int          mismatches;
		int          results_seen;
		int          events;
		int          commands;
		int          dropped;
		int          uart_entries;

		function new();
			base         = BASE_PORT_RESET;
			mismatches   = 0;
			results_seen = 0;
			events       = 0;
			commands     = 0;
			dropped      = 0;
			uart_entries = 0;
			restart();
			reply_bytes.delete();
		endfunction

		function void queue_reply(logic [7:0] b);
			if (reply_bytes.size() < FIFO_DEPTH) begin
				reply_bytes.push_back(b);
			end else begin
				dropped++;
			end
		endfunction

		// port reset: parser and queue cleared, back to intelligent mode, one ack
		function void restart();
			uart_on    = 0;
			param_due  = 0;
			in_sysex   = 0;
			run_status = '0;
			held       = 0;
			needed     = 0;
			first_byte = '0;
			reply_bytes.delete();
			queue_reply(ACK_BYTE);
		endfunction

		function void command(logic [7:0] c);
			param_due = 0;
			commands++;
			case (c)
				CMD_UART_MODE: begin
					queue_reply(ACK_BYTE);
					uart_on = 1;
					uart_entries++;
				end
				CMD_RESET: begin
					restart();
				end
				CMD_VERSION_A, CMD_VERSION_B: begin
					queue_reply(ACK_BYTE);
					queue_reply(REPLY_VERSION);
				end
				CMD_INFO: begin
					queue_reply(ACK_BYTE);
					queue_reply(REPLY_INFO);
				end
				CMD_PARAM_A, CMD_PARAM_B, CMD_PARAM_C: begin
					param_due = 1;
				end
				default: begin
					queue_reply(ACK_BYTE);
				end
			endcase
		endfunction

		function void midi_byte(logic [7:0] b, inout bus_result_t r);
			logic [3:0] kind;
			logic [6:0] second;
			if (in_sysex) begin
				if (b == MIDI_SYSEX_END) in_sysex = 0;
				return;
			end
			if (b >= MIDI_REALTIME || b == MIDI_SYSEX_END) return;
			if (b >= MIDI_SYSEX_START) begin
				if (b == MIDI_SYSEX_START) in_sysex = 1;
				run_status = '0;
				held       = 0;
				needed     = 0;
				return;
			end
			if (b[7]) begin
				run_status = b;
				held       = 0;
				needed     = (b[7:4] == KIND_PROGRAM || b[7:4] == KIND_PRESSURE) ? 1 : 2;
				return;
			end
			if (run_status == 8'h00) return;
			if (held == 0 && needed >= 2) begin
				first_byte = b[6:0];
				held       = 1;
				return;
			end
			kind = run_status[7:4];
			if (needed >= 2) begin
				second = b[6:0];
			end else begin
				first_byte = b[6:0];
				second     = '0;
			end
			if (kind == KIND_NOTE_ON && second == 7'd0) kind = KIND_NOTE_OFF;
			r.ev_valid = 1'b1;
			r.channel  = run_status[3:0];
			r.kind     = kind;
			r.first    = first_byte;
			r.second   = second;
			held       = 0;
			events++;
		endfunction

		function void note_access(logic wr, logic [15:0] addr, logic [7:0] wd);
			bus_result_t r;
			logic [16:0] cmd_addr;
			bit          at_cmd;
			bit          at_data;
			r        = '{default: '0};
			cmd_addr = {1'b0, base} + 17'd1;
			at_cmd   = ({1'b0, addr} == cmd_addr);
			at_data  = (addr == base);
			if (!wr) begin
				if (at_cmd) begin
					r.read_data = (reply_bytes.size() == 0) ? STATUS_EMPTY : STATUS_READY;
				end else if (at_data) begin
					if (reply_bytes.size() != 0) r.read_data = reply_bytes.pop_front();
				end else begin
					r.read_data = OPEN_BUS;
				end
			end else if (at_cmd) begin
				if (!uart_on) begin
					command(wd);
				end else if (wd == CMD_RESET) begin
					restart();
				end
			end else if (at_data) begin
				if (!uart_on && param_due) begin
					param_due = 0;
					queue_reply(ACK_BYTE);
				end else begin
					midi_byte(wd, r);
				end
			end
			due.push_back(r);
		endfunction

		function int pending();
			return due.size();
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			if (mismatches < MAX_PRINTS)
				$display("mismatch at %0t, result %0d: %s got %h want %h",
					$time, results_seen, what, got, want);
			mismatches++;
		endtask

		task check_result(logic [31:0] d, logic flag);
			bus_result_t w;
			results_seen++;
			if (due.size() == 0) begin
				report("unexpected result", d, '0);
				return;
			end
			w = due.pop_front();
			if (d[7:0] !== w.read_data)
				report("read_data", 32'(d[7:0]), 32'(w.read_data));
			if (flag !== w.ev_valid)
				report("event_valid", 32'(flag), 32'(w.ev_valid));
			if (d[11:8] !== w.channel)
				report("event_channel", 32'(d[11:8]), 32'(w.channel));
			if (d[15:12] !== w.kind)
				report("event_kind", 32'(d[15:12]), 32'(w.kind));
			if (d[22:16] !== w.first)
				report("event_first", 32'(d[22:16]), 32'(w.first));
			if (d[29:23] !== w.second)
				report("event_second", 32'(d[29:23]), 32'(w.second));
			if (d[31:30] !== 2'b00)
				report("pad bits", 32'(d[31:30]), 32'(2'b00));
		endtask
	endclass

	// clock, reset and block inputs, all known from time zero
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = BASE_PORT_RESET;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;       // port[15:0], write_data[23:16]
	logic        s_tuser   = 1'b0;     // mode (0 read, 1 write)
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;              // read_data[7:0], event_channel[11:8],
	                                   // event_kind[15:12], event_first[22:16],
	                                   // event_second[29:23], zero[31:30]
	logic        m_tuser;              // event_valid

	midi_port_tracker tracker;
	logic [15:0] cur_base    = BASE_PORT_RESET;
	bit          no_gaps     = 0;
	int          sent        = 0;
	int          useful      = 0;
	int          ready_left  = 0;
	int          quiet_cycles = 0;

	midi_port_interface_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// mostly back to back, sometimes a short gap, rarely a long hold
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// result side: random stalls; once no_gaps is set, no new stall begins
	always @(posedge clk) begin
		if (ready_left != 0) begin
			ready_left <= ready_left - 1;
		end else if (no_gaps || $urandom_range(0, 2) != 0) begin
			m_tready   <= 1'b1;
			ready_left <= $urandom_range(0, 12);
		end else begin
			m_tready   <= 1'b0;
			ready_left <= pick_gap();
		end
	end

	// every accepted result is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
			tracker.check_result(m_tdata, m_tuser);
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one bus access; returns at the edge where the transfer happened
	task automatic send_access(input logic wr, input logic [15:0] addr, input logic [7:0] wd);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= wr;
		s_tdata  <= {wd, addr};
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
		tracker.note_access(wr, addr, wd);
		sent++;
		if (addr == cur_base || addr == cur_base + 16'd1) useful++;
	endtask

	task automatic rd_status();
		send_access(1'b0, cur_base + 16'd1, 8'($urandom_range(0, 255)));
	endtask

	task automatic rd_data();
		send_access(1'b0, cur_base, 8'($urandom_range(0, 255)));
	endtask

	task automatic wr_cmd(input logic [7:0] b);
		send_access(1'b1, cur_base + 16'd1, b);
	endtask

	task automatic wr_data(input logic [7:0] b);
		send_access(1'b1, cur_base, b);
	endtask

	// hold off the sender until every expected result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_base(input logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we       <= 1'b0;
		tracker.base = v;
		cur_base     = v;
	endtask

	// channel message, status byte sometimes left to running status,
	// zero velocity now and then, realtime bytes slipped in between
	task automatic send_midi_message();
		logic [3:0] kind;
		logic [7:0] d;
		int         n;
		kind = 4'($urandom_range(8, 14));
		n    = (kind == KIND_PROGRAM || kind == KIND_PRESSURE) ? 1 : 2;
		if ($urandom_range(0, 9) < 6) wr_data({kind, 4'($urandom_range(0, 15))});
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) wr_data(8'($urandom_range(248, 255)));
			d = 8'($urandom_range(0, 127));
			if (i == 1 && $urandom_range(0, 4) == 0) d = 8'h00;
			wr_data(d);
		end
	endtask

	task automatic send_sysex();
		int n;
		n = $urandom_range(0, 5);
		wr_data(MIDI_SYSEX_START);
		repeat (n) begin
			wr_data(8'($urandom_range(0, 255)));
		end
		wr_data(MIDI_SYSEX_END);
	endtask

	task automatic send_command();
		logic [7:0] c;
		int         p;
		p = $urandom_range(0, 9);
		case (p)
			0: c = CMD_VERSION_A;
			1: c = CMD_VERSION_B;
			2: c = CMD_INFO;
			3: c = CMD_PARAM_A;
			4: c = CMD_PARAM_B;
			5: c = CMD_PARAM_C;
			6: c = CMD_RESET;
			default: c = 8'($urandom_range(0, 255));
		endcase
		wr_cmd(c);
		if ((c == CMD_PARAM_A || c == CMD_PARAM_B || c == CMD_PARAM_C)
			&& $urandom_range(0, 3) != 0)
			wr_data(8'($urandom_range(0, 255)));
	endtask

	// uart mode: commands other than reset are ignored, midi still parsed
	task automatic uart_session();
		int n;
		n = $urandom_range(1, 6);
		wr_cmd(CMD_UART_MODE);
		repeat (n) begin
			case ($urandom_range(0, 2))
				0: send_midi_message();
				1: wr_cmd(8'($urandom_range(0, 254)));
				default: rd_data();
			endcase
		end
		if ($urandom_range(0, 4) != 0) wr_cmd(CMD_RESET);
	endtask

	// pile up replies, often past the queue depth, then drain them
	task automatic overfill_replies();
		int n;
		n = $urandom_range(8, 20);
		repeat (n) begin
			send_command();
		end
		n = $urandom_range(10, 24);
		repeat (n) begin
			if ($urandom_range(0, 3) == 0) rd_status();
			else rd_data();
		end
	endtask

	task automatic random_phase(input int target);
		int start;
		int pick;
		start = useful;
		while (useful - start < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				send_midi_message();
			end else if (pick < 38) begin
				send_sysex();
			end else if (pick < 58) begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 9) < 7) rd_data();
					else rd_status();
				end
			end else if (pick < 73) begin
				send_command();
			end else if (pick < 78) begin
				uart_session();
			end else if (pick < 86) begin
				// stray access anywhere on the bus
				send_access(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)));
			end else if (pick < 90) begin
				// odd bytes into the parser: sysex start, system common, stray end of sysex
				wr_data(8'($urandom_range(240, 247)));
			end else if (pick < 95) begin
				overfill_replies();
			end else begin
				repeat ($urandom_range(2, 8)) send_midi_message();
			end
		end
	endtask

	initial begin
		tracker = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_base(BASE_PORT_RESET);

		// directed: empty reads, open bus, replies, parameters, parser corners
		rd_status();
		rd_data();
		send_access(1'b0, 16'h0000, 8'h00);
		send_access(1'b1, 16'hFFFF, 8'hFF);
		wr_cmd(CMD_VERSION_A);
		rd_status();
		rd_data();
		rd_data();
		wr_cmd(CMD_INFO);
		wr_cmd(CMD_PARAM_A);
		wr_data(8'h90);                 // swallowed as a parameter, acked
		wr_cmd(CMD_PARAM_C);
		wr_cmd(8'h00);                  // a new command cancels the parameter
		wr_data(8'h9F);
		wr_data(8'h7F);
		wr_data(MIDI_REALTIME);         // realtime inside a message
		wr_data(8'h00);                 // note-on at zero velocity
		wr_data(8'hC0);
		wr_data(8'h05);                 // one-byte message
		wr_data(MIDI_SYSEX_START);
		wr_data(8'h91);                 // ignored inside sysex
		wr_data(MIDI_SYSEX_END);
		wr_data(8'h40);                 // data with no running status
		wr_data(MIDI_SYSEX_END);        // stray end of sysex
		wr_data(8'hF3);                 // system common clears running status
		wr_cmd(CMD_UART_MODE);
		wr_cmd(CMD_VERSION_B);          // ignored in uart mode
		wr_cmd(CMD_RESET);

		random_phase(450);
		drain();

		write_base(16'h0000);
		no_gaps = 1;
		random_phase(150);
		no_gaps = 0;
		random_phase(200);
		drain();

		write_base(16'hFFFE);
		random_phase(350);
		drain();

		write_base(16'($urandom_range(1, 65533)));
		random_phase(350);
		drain();

		write_base(BASE_PORT_RESET);
		random_phase(350);
		drain();

		$display("ran %0d accesses (%0d to the ports) over five base addresses, %0d checked",
			sent, useful, tracker.results_seen);
		$display("seen %0d midi events, %0d commands, %0d uart entries, %0d replies lost",
			tracker.events, tracker.commands, tracker.uart_entries, tracker.dropped);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/mpi_pkg.sv
rtl/mpi_reply_fifo.sv
rtl/mpi_parser.sv
rtl/midi_port_interface_unit.sv
tb/midi_port_interface_unit_test.sv
